FILE: rtl/lpsd_pkg.sv
// ----------------------------------------------------------------------------
// lpsd_pkg
// Shared types and constants of the length-prefixed SDNV decoder.
// ----------------------------------------------------------------------------
package lpsd_pkg;

	localparam int MAX_VALUE_BYTES_DEF = 8;
	localparam int VALUE_W             = 64;
	localparam int USED_W              = 4;
	localparam int OUT_TDATA_W         = 72;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_TRUNC = 2'd1,
		ST_OVFL  = 2'd2
	} status_t;

	typedef struct packed {
		logic       eob;
		logic [7:0] data;
	} in_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [USED_W-1:0]  used;
		status_t            status;
	} result_t;

endpackage

FILE: rtl/length_prefixed_sdnv_decoder.sv
// ----------------------------------------------------------------------------
// length_prefixed_sdnv_decoder
// Decodes a byte stream of length-prefixed SDNVs into 64-bit values.
//
// Input channel (s_*): one encoded byte per request, s_tlast marks the last
// byte available in the buffer. Output channel (m_*): one request per
// finished or failed value, carrying value, bytes used and status.
// A taken byte is held in the input register and decoded from there; the
// output register, which drives m_*, loads each result that completes.
// One byte per cycle is sustained unless a completing byte meets a held
// result; bytes that end no value pass even while a result waits. The
// shift-or into the accumulator in the decode stage sets that rate.
// When the receiver stalls, the result holds in the output register and
// the next completing byte waits in the input register; s_tready falls
// only then. Reset clears the decoder to wait for a leading byte and
// empties both registers.
// ----------------------------------------------------------------------------
module length_prefixed_sdnv_decoder
	import lpsd_pkg::*;
#(
	parameter int MAX_VALUE_BYTES = MAX_VALUE_BYTES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,   // data_byte
	input  logic                   s_tlast,   // end_of_buffer
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata    // decoded_value, bytes_used, status, pad
);

	in_item_t item_in;
	in_item_t item_s1;
	logic     valid_s1;
	logic     advance;
	logic     res_valid;
	logic     out_free;
	result_t  res;
	result_t  res_q;

	assign item_in  = {s_tlast, s_tdata};
	assign s_tready = !valid_s1 || advance;

	lpsd_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (s_tvalid && s_tready),
		.drain    (advance),
		.item_in  (item_in),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	lpsd_decode #(
		.MAX_VALUE_BYTES (MAX_VALUE_BYTES)
	) u_dec (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.out_free  (out_free),
		.advance   (advance),
		.res_valid (res_valid),
		.res       (res)
	);

	lpsd_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && res_valid),
		.res_in   (res),
		.take     (m_tready),
		.out_free (out_free),
		.valid_q  (m_tvalid),
		.res_q    (res_q)
	);

	assign m_tdata = {2'b00, res_q.status, res_q.used, res_q.value};

endmodule

FILE: rtl/lpsd_in_reg.sv
// ----------------------------------------------------------------------------
// lpsd_in_reg
// Input register: holds one accepted byte until the decode stage takes it.
// ----------------------------------------------------------------------------
module lpsd_in_reg
	import lpsd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     load,
	input  logic     drain,
	input  in_item_t item_in,
	output logic     valid_s1,
	output in_item_t item_s1
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (drain) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item_in;
		end
	end

endmodule

FILE: rtl/lpsd_decode.sv
// ----------------------------------------------------------------------------
// lpsd_decode
// Decode state and single-pass step logic: one byte per advance.
// ----------------------------------------------------------------------------
module lpsd_decode
	import lpsd_pkg::*;
#(
	parameter int MAX_VALUE_BYTES = MAX_VALUE_BYTES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     valid_s1,
	input  in_item_t item_s1,
	input  logic     out_free,
	output logic     advance,
	output logic     res_valid,
	output result_t  res
);

	// widest value that can still be reported as ok
	localparam int ACC_W = (MAX_VALUE_BYTES >= 8) ? VALUE_W : 8 * MAX_VALUE_BYTES + 4;
	localparam logic [3:0] MAX_CNT = 4'(MAX_VALUE_BYTES);

	logic             collecting_q;
	logic [3:0]       left_q;
	logic [3:0]       total_q;
	logic             ovf_q;
	logic [ACC_W-1:0] acc_q;

	logic             collecting_d;
	logic [3:0]       left_d;
	logic [3:0]       total_d;
	logic             ovf_d;
	logic [ACC_W-1:0] acc_d;

	logic [3:0]       count;
	logic [3:0]       nib;
	logic [3:0]       left_dec;
	logic [ACC_W-1:0] acc_shift;

	assign count     = {1'b0, item_s1.data[6:4]} + 4'd1;
	assign nib       = item_s1.data[3:0];
	assign left_dec  = left_q - 4'd1;
	assign acc_shift = {acc_q[ACC_W-9:0], item_s1.data};

	always_comb begin
		res_valid    = 1'b0;
		res.value    = '0;
		res.used     = 4'd1;
		res.status   = ST_OK;
		collecting_d = collecting_q;
		left_d       = left_q;
		total_d      = total_q;
		ovf_d        = ovf_q;
		acc_d        = acc_q;
		if (!collecting_q) begin
			if (!item_s1.data[7]) begin
				res_valid = 1'b1;
				res.value = VALUE_W'(item_s1.data[6:0]);
			end else if (item_s1.eob) begin
				res_valid  = 1'b1;
				res.status = ST_TRUNC;
			end else begin
				collecting_d = 1'b1;
				left_d       = count;
				total_d      = count + 4'd1;
				acc_d        = ACC_W'(nib);
				ovf_d        = ((count == 4'd8) && (nib != 4'd0)) || (count > MAX_CNT);
			end
		end else begin
			acc_d  = acc_shift;
			left_d = left_dec;
			if (left_dec == 4'd0) begin
				res_valid = 1'b1;
				res.used  = total_q;
				if (ovf_q) begin
					res.status = ST_OVFL;
				end else begin
					res.value = VALUE_W'(acc_shift);
				end
			end else if (item_s1.eob) begin
				res_valid  = 1'b1;
				res.used   = total_q - left_dec;
				res.status = ST_TRUNC;
			end
		end
		if (res_valid) begin
			collecting_d = 1'b0;
			left_d       = 4'd0;
			total_d      = 4'd0;
			ovf_d        = 1'b0;
		end
	end

	assign advance = valid_s1 && (!res_valid || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q <= 1'b0;
			left_q       <= 4'd0;
			total_q      <= 4'd0;
			ovf_q        <= 1'b0;
		end else if (advance) begin
			collecting_q <= collecting_d;
			left_q       <= left_d;
			total_q      <= total_d;
			ovf_q        <= ovf_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			acc_q <= acc_d;
		end
	end

endmodule

FILE: rtl/lpsd_out_reg.sv
// ----------------------------------------------------------------------------
// lpsd_out_reg
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module lpsd_out_reg
	import lpsd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res_in,
	input  logic    take,
	output logic    out_free,
	output logic    valid_q,
	output result_t res_q
);

	assign out_free = !valid_q || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

FILE: rtl/lpsd_checker.sv
// ----------------------------------------------------------------------------
// lpsd_checker
// Port-level checks on the decoder's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module lpsd_checker
	import lpsd_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	logic [1:0] st;
	logic [3:0] used;

	assign st   = m_tdata[69:68];
	assign used = m_tdata[67:64];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed under stall");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (st == ST_OK) || (st == ST_TRUNC) || (st == ST_OVFL))
		else $error("bad status code");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (st != ST_OK) |-> m_tdata[63:0] == 64'd0)
		else $error("error result with nonzero value");

	a_used: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (used != 4'd0) && (used <= 4'd9))
		else $error("bytes used out of range");

	a_short: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (st == ST_OK) && (used == 4'd1) |-> m_tdata[63:7] == 57'd0)
		else $error("one-byte value above 127");

endmodule

bind length_prefixed_sdnv_decoder lpsd_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: verif/tb_length_prefixed_sdnv_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_length_prefixed_sdnv_decoder
// Streams encoded bytes into the decoder and checks every decoded value.
//
// A directed run covers short values, the largest value, truncation on the
// leading byte and mid-value, an end mark on the final byte, and overflow.
// A random run follows, mostly well-formed values of every length with
// random content, plus some truncated values and noise bytes. A scoreboard
// predicts each result from the accepted bytes and checks the output
// requests in order. Both sides idle in bursts. The receiver also holds off
// once for a long stretch so that the input stalls.
// ----------------------------------------------------------------------------
module tb_length_prefixed_sdnv_decoder;
	import lpsd_pkg::*;

	localparam int RANDOM_BYTES = 600;
	localparam int CALM_AFTER   = 480;
	localparam int HOLD_AT      = 250;
	localparam int HOLD_CYCLES  = 300;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 10;

	class decode_checker;
		logic              in_value;
		logic [3:0]        left;
		logic [3:0]        length;
		logic [63:0]       acc;
		logic              too_big;
		result_t           pending_values[$];
		int                errors;
		int                n_ok;
		int                n_trunc;
		int                n_ovfl;

		function new();
			clear();
			errors  = 0;
			n_ok    = 0;
			n_trunc = 0;
			n_ovfl  = 0;
		endfunction

		function void clear();
			in_value = 1'b0;
			left     = '0;
			length   = '0;
			acc      = '0;
			too_big  = 1'b0;
		endfunction

		function void post(logic [63:0] value, logic [3:0] used, status_t status);
			result_t r;
			r.value  = value;
			r.used   = used;
			r.status = status;
			pending_values.push_back(r);
			clear();
		endfunction

		// one accepted input request
		function void take_byte(logic [7:0] b, logic eob);
			logic [3:0] count;
			if (!in_value) begin
				if (!b[7]) begin
					post({57'd0, b[6:0]}, 4'd1, ST_OK);
				end else begin
					count = {1'b0, b[6:4]} + 4'd1;
					if (eob) begin
						post('0, 4'd1, ST_TRUNC);
					end else begin
						in_value = 1'b1;
						left     = count;
						length   = count + 4'd1;
						acc      = {60'd0, b[3:0]};
						too_big  = (count == 4'd8 && b[3:0] != 4'd0) ||
							(int'(count) > MAX_VALUE_BYTES_DEF);
					end
				end
			end else begin
				acc  = {acc[55:0], b};
				left = left - 4'd1;
				if (left == 4'd0) begin
					if (too_big)
						post('0, length, ST_OVFL);
					else
						post(acc, length, ST_OK);
				end else if (eob) begin
					post('0, length - left, ST_TRUNC);
				end
			end
		endfunction

		// one accepted output request
		function void match_result(logic [OUT_TDATA_W-1:0] word);
			result_t want;
			logic [63:0] got_value;
			logic [3:0]  got_used;
			logic [1:0]  got_status;
			got_value  = word[63:0];
			got_used   = word[67:64];
			got_status = word[69:68];
			if (pending_values.size() == 0) begin
				$display("%0t: unexpected result value %h used %0d status %0d",
					$time, got_value, got_used, got_status);
				errors++;
				return;
			end
			want = pending_values.pop_front();
			if (got_value !== want.value) begin
				$display("%0t: value mismatch, expected %h actual %h",
					$time, want.value, got_value);
				errors++;
			end
			if (got_used !== want.used) begin
				$display("%0t: bytes used mismatch, expected %0d actual %0d",
					$time, want.used, got_used);
				errors++;
			end
			if (got_status !== want.status) begin
				$display("%0t: status mismatch, expected %0d actual %0d",
					$time, want.status, got_status);
				errors++;
			end
			case (want.status)
				ST_OK:    n_ok++;
				ST_TRUNC: n_trunc++;
				default:  n_ovfl++;
			endcase
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [7:0]             s_tdata;   // data_byte
	logic                   s_tlast;   // end_of_buffer
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // decoded_value, bytes_used, status, pad

	decode_checker tracker;
	int  bytes_sent;
	int  random_sent;
	bit  calm;
	bit  sender_lively;
	bit  recv_lively;
	bit  hold_done;
	int  idle_cycles;

	// {end mark, byte}
	logic [8:0] directed_bytes[] = '{
		9'h000,                                     // zero
		9'h17f,                                     // largest short value, end mark
		9'h180,                                     // end mark on a leading byte
		9'h080, 9'h000,                             // two-byte zero
		9'h08f, 9'h1ff,                             // end mark on the final byte
		9'h0f0, 9'h0ff, 9'h0ff, 9'h0ff, 9'h0ff,     // all ones, nine bytes
		9'h0ff, 9'h0ff, 9'h0ff, 9'h0ff,
		9'h0f1, 9'h100,                             // truncation beats overflow
		9'h0f1, 9'h012, 9'h034, 9'h056, 9'h078,     // overflow, all bytes taken
		9'h09a, 9'h0bc, 9'h0de, 9'h0f0
	};

	length_prefixed_sdnv_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic send_byte(input logic [7:0] b, input logic eob);
		int gap;
		if (!calm && sender_lively && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eob;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.take_byte(b, eob);
		bytes_sent++;
	endtask

	task automatic send_number();
		int kind;
		int cnt;
		int cut;
		logic [3:0] nib;
		logic eob;
		kind = $urandom_range(0, 99);
		if ($urandom_range(0, 19) == 0)
			sender_lively = !sender_lively;
		if (kind < 10) begin
			send_byte(8'($urandom), 1'($urandom));
			random_sent++;
		end else if (kind < 35) begin
			send_byte({1'b0, 7'($urandom)}, $urandom_range(0, 9) == 0);
			random_sent++;
		end else begin
			cnt = $urandom_range(1, 8);
			if (cnt == 8 && $urandom_range(0, 3) != 0)
				nib = 4'd0;
			else
				nib = 4'($urandom);
			cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, cnt - 1) : -1;
			send_byte({1'b1, 3'(cnt - 1), nib}, cut == 0);
			random_sent++;
			if (cut == 0)
				return;
			for (int i = 1; i <= cnt; i++) begin
				eob = (i == cut) || (i == cnt && $urandom_range(0, 4) == 0);
				send_byte(8'($urandom), eob);
				random_sent++;
				if (i == cut)
					return;
			end
		end
	endtask

	// receiver
	initial begin
		m_tready <= 1'b0;
		recv_lively = 1'b1;
		hold_done   = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (!hold_done && bytes_sent >= HOLD_AT) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && recv_lively && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
				if ($urandom_range(0, 39) == 0)
					recv_lively = !recv_lively;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.match_result(m_tdata);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		tracker       = new();
		bytes_sent    = 0;
		random_sent   = 0;
		calm          = 1'b0;
		sender_lively = 1'b1;
		idle_cycles   = 0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tlast  <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_bytes[i])
			send_byte(directed_bytes[i][7:0], directed_bytes[i][8]);

		while (random_sent < RANDOM_BYTES) begin
			if (random_sent >= CALM_AFTER)
				calm = 1'b1;
			send_number();
		end
		s_tvalid <= 1'b0;

		while (tracker.pending_values.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d bytes, %0d results: %0d ok, %0d truncated, %0d overflowed",
			bytes_sent, tracker.n_ok + tracker.n_trunc + tracker.n_ovfl,
			tracker.n_ok, tracker.n_trunc, tracker.n_ovfl);
		$display("Lengths 1 to 9 bytes, end marks on every position, one long output stall");
		if (tracker.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: files.f
rtl/lpsd_pkg.sv
rtl/lpsd_in_reg.sv
rtl/lpsd_decode.sv
rtl/lpsd_out_reg.sv
rtl/length_prefixed_sdnv_decoder.sv
rtl/lpsd_checker.sv
verif/tb_length_prefixed_sdnv_decoder.sv
